### design/hmcg_pkg.sv
// Shared types, constants and helper functions for the hex mesh connectivity generator.
`timescale 1ns / 1ps

package hmcg_pkg;

   // Largest grid edge, in elements.
   localparam int MAX_RES = 256;

   // Field widths fixed by the interface.
   localparam int RES_W   = 9;
   localparam int COUNT_W = 24;
   localparam int NODE_W  = 25;

   // Internal widths that follow from MAX_RES.
   localparam int POS_W   = $clog2(MAX_RES);
   localparam int LAT_W   = $clog2(MAX_RES + 2);
   localparam int PLANE_W = $clog2((MAX_RES + 1) * (MAX_RES + 1) + 1);
   localparam int ROW_W   = $clog2((MAX_RES + 1) * MAX_RES + 1);
   localparam int ZMUL_W  = PLANE_W + LAT_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RES_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RES_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RES_Z = 2'd2;

   // Stream payload widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = COUNT_W + 8 * NODE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // request transaction accepted this cycle
      logic mul1;    // plane size and row offsets
      logic mul2;    // layer offsets
      logic emit;    // corner sums into output register, step the walk
   } dp_cmd_type;

   // Register value clamped into 1..MAX_RES.
   function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] v;
      v = r;
      if (r == '0) begin
         v = RES_W'(1);
      end else if (r > RES_W'(MAX_RES)) begin
         v = RES_W'(MAX_RES);
      end
      return v;
   endfunction

endpackage

### design/hex_mesh_connectivity_generator_top.sv
// Top level of the structured hex mesh connectivity generator.
`timescale 1ns / 1ps

// Structured hex mesh connectivity generator. Each request transaction
// yields one response transaction describing one hexahedral element of a
// res_x by res_y by res_z grid: its running element number and the eight
// corner node indices on the (res+1)^3 lattice, numbered x fastest, with the
// y coordinate mirrored (row res_y-ey on top). Elements are walked y fastest,
// then x, then z; rsp_tlast marks the grid's last element, after which the
// walk wraps to element 0. Setting restart in a request starts again at
// element 0 before that element is produced. Resolutions are written through
// the csr_ port (index 0 res_x, 1 res_y, 2 res_z; a value of 0 acts as 1 and
// values above 256 act as 256); every write to one of these registers sends
// the walk home, and writes must only be made while no request is in flight.
// Sequencing: a request is taken only in the idle state, and the sequencer
// runs its element through two multiply steps (plane size with row offsets,
// then layer offsets) and one add step that loads the output register; no
// new request is taken before that add step. A response left waiting does
// not block the next request; the add step holds until the output register
// is free.
module hex_mesh_connectivity_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hmcg_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] restart, rest zero
   // Response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // element_index[23:0], corner_a..corner_h 25 bits each from bit 24 upward
   output logic [hmcg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,  // final_element
   // Configuration write port
   input  logic                                csr_wen,
   input  logic [hmcg_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [hmcg_pkg::RES_W-1:0]          csr_wdata
);

   hmcg_pkg::dp_cmd_type cmd;

   // Sequencer: owns the handshakes and the response valid flag.
   hmcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath: registers, walk counters, node index arithmetic, payload.
   hmcg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .restart   (req_tdata[0]),
      .cmd       (cmd),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

### design/hmcg_ctrl.sv
// Control state machine: request handshake, compute sequencing and response valid.
`timescale 1ns / 1ps

module hmcg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output hmcg_pkg::dp_cmd_type cmd
);

   hmcg_pkg::ctrl_state_type state_ff, state_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmcg_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hmcg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = hmcg_pkg::ST_MUL1;
            end
         end
         hmcg_pkg::ST_MUL1: state_in = hmcg_pkg::ST_MUL2;
         hmcg_pkg::ST_MUL2: state_in = hmcg_pkg::ST_EMIT;
         hmcg_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = hmcg_pkg::ST_IDLE;
            end
         end
         default: state_in = hmcg_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         hmcg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         hmcg_pkg::ST_MUL1: cmd.mul1 = 1'b1;
         hmcg_pkg::ST_MUL2: cmd.mul2 = 1'b1;
         hmcg_pkg::ST_EMIT: cmd.emit = out_free;
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;

`ifndef NO_ASSERTIONS
   // The output register is only loaded when its previous transaction has left.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

   // An accepted request always starts the multiply sequence.
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == hmcg_pkg::ST_MUL1))
      else $error("accepted request did not start compute");

   // A response appears only as the emit step completes.
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == hmcg_pkg::ST_EMIT))
      else $error("response valid without emit step");
`endif

endmodule

### design/hmcg_datapath.sv
// Datapath: resolution registers, walk position, node index multiplies and output register.
`timescale 1ns / 1ps

module hmcg_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [hmcg_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [hmcg_pkg::RES_W-1:0]            csr_wdata,
   input  logic                                  restart,
   input  hmcg_pkg::dp_cmd_type                  cmd,
   output logic [hmcg_pkg::RSP_DATA_W-1:0]       rsp_data,
   output logic                                  rsp_last
);

   localparam int RES_W   = hmcg_pkg::RES_W;
   localparam int POS_W   = hmcg_pkg::POS_W;
   localparam int LAT_W   = hmcg_pkg::LAT_W;
   localparam int NODE_W  = hmcg_pkg::NODE_W;
   localparam int COUNT_W = hmcg_pkg::COUNT_W;
   localparam int PLANE_W = hmcg_pkg::PLANE_W;
   localparam int ROW_W   = hmcg_pkg::ROW_W;
   localparam int ZMUL_W  = hmcg_pkg::ZMUL_W;

   // Configuration.
   logic [RES_W-1:0] res_x_ff, res_x_in;
   logic [RES_W-1:0] res_y_ff, res_y_in;
   logic [RES_W-1:0] res_z_ff, res_z_in;
   logic             cfg_hit;

   // Walk state.
   logic [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [POS_W-1:0]   pos_z_ff, pos_z_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Intermediate products.
   logic [PLANE_W-1:0] plane_ff;
   logic [ROW_W-1:0]   row_t_ff, row_b_ff;
   logic [NODE_W-1:0]  zoff0_ff, zoff1_ff;

   // Output register.
   logic [COUNT_W-1:0] out_index_ff;
   logic [NODE_W-1:0]  out_corner_ff [8];
   logic               out_last_ff;

   logic [RES_W-1:0]   rx, ry, rz;
   logic [LAT_W-1:0]   nnx, nny;
   logic [RES_W-1:0]   yt, yb;
   logic [2*LAT_W-1:0] plane_prod;
   logic [LAT_W+RES_W-1:0] row_t_prod, row_b_prod;
   logic [LAT_W-1:0]   z0, z1;
   logic [ZMUL_W-1:0]  zoff0_prod, zoff1_prod;
   logic [NODE_W-1:0]  x0, x1, rt, rb;
   logic               last;
   logic               wrap_y, wrap_x, wrap_z;

   assign rx  = hmcg_pkg::eff_res(res_x_ff);
   assign ry  = hmcg_pkg::eff_res(res_y_ff);
   assign rz  = hmcg_pkg::eff_res(res_z_ff);
   assign nnx = LAT_W'(rx) + LAT_W'(1);
   assign nny = LAT_W'(ry) + LAT_W'(1);

   // Mirrored rows: top row ry - y, bottom row one below.
   assign yt = ry - RES_W'(pos_y_ff);
   assign yb = yt - RES_W'(1);

   assign plane_prod = nnx * nny;
   assign row_t_prod = nnx * yt;
   assign row_b_prod = nnx * yb;

   assign z0 = LAT_W'(pos_z_ff);
   assign z1 = z0 + LAT_W'(1);
   assign zoff0_prod = plane_ff * z0;
   assign zoff1_prod = plane_ff * z1;

   assign x0 = NODE_W'(pos_x_ff);
   assign x1 = x0 + NODE_W'(1);
   assign rt = NODE_W'(row_t_ff);
   assign rb = NODE_W'(row_b_ff);

   assign last = (RES_W'(pos_x_ff) == rx - RES_W'(1))
              && (RES_W'(pos_y_ff) == ry - RES_W'(1))
              && (RES_W'(pos_z_ff) == rz - RES_W'(1));

   assign wrap_y = (RES_W'(pos_y_ff) + RES_W'(1)) >= ry;
   assign wrap_x = (RES_W'(pos_x_ff) + RES_W'(1)) >= rx;
   assign wrap_z = (RES_W'(pos_z_ff) + RES_W'(1)) >= rz;

   // Register writes; any hit sends the walk home.
   always_comb begin
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      res_z_in = res_z_ff;
      cfg_hit  = 1'b0;
      if (csr_wen) begin
         case (csr_addr)
            hmcg_pkg::CSR_RES_X: begin
               res_x_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            hmcg_pkg::CSR_RES_Y: begin
               res_y_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            hmcg_pkg::CSR_RES_Z: begin
               res_z_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Walk: y fastest, then x, then z.
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      count_in = count_ff;
      if (cmd.load && restart) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         count_in = '0;
      end
      if (cmd.emit) begin
         if (last) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
            count_in = '0;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            if (!wrap_y) begin
               pos_y_in = pos_y_ff + POS_W'(1);
            end else begin
               pos_y_in = '0;
               if (!wrap_x) begin
                  pos_x_in = pos_x_ff + POS_W'(1);
               end else begin
                  pos_x_in = '0;
                  pos_z_in = wrap_z ? '0 : pos_z_ff + POS_W'(1);
               end
            end
         end
      end
      if (cfg_hit) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_x_ff <= RES_W'(1);
         res_y_ff <= RES_W'(1);
         res_z_ff <= RES_W'(1);
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         count_ff <= '0;
      end else begin
         res_x_ff <= res_x_in;
         res_y_ff <= res_y_in;
         res_z_ff <= res_z_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         count_ff <= count_in;
      end
   end

   // Payload pipeline, no reset.
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         plane_ff <= plane_prod[PLANE_W-1:0];
         row_t_ff <= row_t_prod[ROW_W-1:0];
         row_b_ff <= row_b_prod[ROW_W-1:0];
      end
      if (cmd.mul2) begin
         zoff0_ff <= zoff0_prod[NODE_W-1:0];
         zoff1_ff <= zoff1_prod[NODE_W-1:0];
      end
      if (cmd.emit) begin
         out_index_ff     <= count_ff;
         out_corner_ff[0] <= zoff0_ff + rt + x0;
         out_corner_ff[1] <= zoff0_ff + rt + x1;
         out_corner_ff[2] <= zoff0_ff + rb + x1;
         out_corner_ff[3] <= zoff0_ff + rb + x0;
         out_corner_ff[4] <= zoff1_ff + rt + x0;
         out_corner_ff[5] <= zoff1_ff + rt + x1;
         out_corner_ff[6] <= zoff1_ff + rb + x1;
         out_corner_ff[7] <= zoff1_ff + rb + x0;
         out_last_ff      <= last;
      end
   end

   assign rsp_data = {out_corner_ff[7], out_corner_ff[6], out_corner_ff[5], out_corner_ff[4],
                      out_corner_ff[3], out_corner_ff[2], out_corner_ff[1], out_corner_ff[0],
                      out_index_ff};
   assign rsp_last = out_last_ff;

`ifndef NO_ASSERTIONS
   // The walk never leaves the grid.
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (RES_W'(pos_y_ff) < ry) && (RES_W'(pos_x_ff) < rx) && (RES_W'(pos_z_ff) < rz))
      else $error("walk position outside grid");

   // Emitting the last element returns the walk to element zero.
   a_wrap_home: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && last) |=> (pos_x_ff == '0 && pos_y_ff == '0
                              && pos_z_ff == '0 && count_ff == '0))
      else $error("walk did not wrap after last element");

   // Neighboring corners along x differ by one node.
   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.emit) |-> (out_corner_ff[1] == out_corner_ff[0] + NODE_W'(1)))
      else $error("corner b is not next to corner a");
`endif

endmodule

### bench/tb_hex_mesh_connectivity_generator_top.sv
// Self-checking testbench for the hex mesh connectivity generator top level.
`timescale 1ns / 1ps

module tb_hex_mesh_connectivity_generator_top;

   // Index 3 has no register behind it; a write there must leave the walk alone.
   localparam logic [hmcg_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   localparam int ITEM_TARGET  = 1800;     // random requests after the directed table
   localparam int CSR_SETTLE   = 8;        // idle cycles before a register write
   localparam int TAIL_CYCLES  = 16;       // quiet cycles after the last response
   localparam int HOLD_CYCLES  = 300;      // long response back-pressure stretch
   localparam int CYCLE_LIMIT  = 500000;   // watchdog
   localparam int PRINT_LIMIT  = 40;       // mismatch lines printed before going quiet

   // One element as it appears on the response side: {rsp_tlast, rsp_tdata}.
   // corner[0] is corner_a (lowest bits above the index), corner[7] is corner_h.
   typedef struct packed {
      logic                                   final_elem;
      logic [7:0][hmcg_pkg::NODE_W-1:0]       corner;
      logic [hmcg_pkg::COUNT_W-1:0]           index;
   } hex_elem_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // Directed stimulus row: either a register write or a request transaction,
   // optionally with the element typed in by hand.
   typedef struct {
      row_kind_type                           kind;
      logic [hmcg_pkg::CSR_ADDR_W-1:0]        addr;
      logic [hmcg_pkg::RES_W-1:0]             wdata;
      bit                                     restart;
      bit                                     pinned;
      hex_elem_type                           want;
   } stim_row_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [hmcg_pkg::REQ_DATA_W-1:0]     req_tdata = '0;   // [0] restart, rest zero
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [hmcg_pkg::RSP_DATA_W-1:0]     rsp_tdata;        // element_index, corner_a .. corner_h
   logic                                rsp_tlast;        // final_element
   logic                                csr_wen = 1'b0;
   logic [hmcg_pkg::CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [hmcg_pkg::RES_W-1:0]          csr_wdata = '0;

   hex_mesh_connectivity_generator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Grid walk predictor: its own copy of the resolution registers and of
   // the walk position, stepped once per accepted request transaction.
   // ---------------------------------------------------------------------
   logic [hmcg_pkg::RES_W-1:0]   grid_res [3];
   int                           walk_x, walk_y, walk_z;
   logic [hmcg_pkg::COUNT_W-1:0] walk_count;

   hex_elem_type       pending_elements [$];   // elements owed by the block, oldest first
   stim_row_type       directed_rows [$];      // directed table, walked in order

   int  mismatch_count = 0;
   int  requests_sent  = 0;
   int  restarts_sent  = 0;
   int  wraps_seen     = 0;
   int  csr_writes     = 0;
   int  cycle_count    = 0;
   int  burst_left     = 1;
   bit  offering       = 1'b0;   // mirrors req_tvalid as scheduled this step
   bit  hold_trigger   = 1'b0;   // set by stimulus, consumed by the receiver
   bit  hold_done      = 1'b0;

   // A register of 0 acts as 1, anything above MAX_RES acts as MAX_RES.
   function automatic int effective_edge(logic [hmcg_pkg::RES_W-1:0] r);
      if (r == 0) return 1;
      if (r > hmcg_pkg::MAX_RES) return hmcg_pkg::MAX_RES;
      return int'(r);
   endfunction

   function automatic logic [hmcg_pkg::NODE_W-1:0] lattice_node(longint nnx, longint nny,
                                                               longint x, longint y,
                                                               longint z);
      return hmcg_pkg::NODE_W'(nnx * nny * z + nnx * y + x);
   endfunction

   function automatic void send_home();
      walk_x = 0;
      walk_y = 0;
      walk_z = 0;
      walk_count = '0;
   endfunction

   function automatic void apply_csr(logic [hmcg_pkg::CSR_ADDR_W-1:0] addr,
                                     logic [hmcg_pkg::RES_W-1:0] data);
      case (addr)
         hmcg_pkg::CSR_RES_X: grid_res[0] = data;
         hmcg_pkg::CSR_RES_Y: grid_res[1] = data;
         hmcg_pkg::CSR_RES_Z: grid_res[2] = data;
         default: return;          // unknown index: no register, no walk reset
      endcase
      send_home();
   endfunction

   // Element produced by one request, then the walk steps (y fastest, then x, then z).
   function automatic hex_elem_type next_element(bit restart);
      int           rx, ry, rz;
      longint       nnx, nny, x0, x1, yt, yb, z0, z1;
      hex_elem_type e;
      rx = effective_edge(grid_res[0]);
      ry = effective_edge(grid_res[1]);
      rz = effective_edge(grid_res[2]);
      nnx = rx + 1;
      nny = ry + 1;
      if (restart) send_home();
      x0 = walk_x;
      x1 = x0 + 1;
      yt = ry - walk_y;             // y mirrored: row ey sits between res_y-ey and res_y-ey-1
      yb = yt - 1;
      z0 = walk_z;
      z1 = z0 + 1;
      e.index     = walk_count;
      e.corner[0] = lattice_node(nnx, nny, x0, yt, z0);
      e.corner[1] = lattice_node(nnx, nny, x1, yt, z0);
      e.corner[2] = lattice_node(nnx, nny, x1, yb, z0);
      e.corner[3] = lattice_node(nnx, nny, x0, yb, z0);
      e.corner[4] = lattice_node(nnx, nny, x0, yt, z1);
      e.corner[5] = lattice_node(nnx, nny, x1, yt, z1);
      e.corner[6] = lattice_node(nnx, nny, x1, yb, z1);
      e.corner[7] = lattice_node(nnx, nny, x0, yb, z1);
      e.final_elem = (walk_x == rx - 1) && (walk_y == ry - 1) && (walk_z == rz - 1);
      if (e.final_elem) begin
         send_home();
      end else begin
         walk_count = walk_count + 1'b1;
         walk_y++;
         if (walk_y >= ry) begin
            walk_y = 0;
            walk_x++;
            if (walk_x >= rx) begin
               walk_x = 0;
               walk_z++;
               if (walk_z >= rz) walk_z = 0;
            end
         end
      end
      return e;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid stays up across a burst; between bursts it may drop
   // for a random gap. The expectation is queued at the accepting edge.
   // ---------------------------------------------------------------------
   task automatic send_request(bit restart, bit pinned, hex_elem_type pinned_val);
      hex_elem_type predicted;
      int           gap;
      req_tdata  <= hmcg_pkg::REQ_DATA_W'(restart);
      req_tvalid <= 1'b1;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = next_element(restart);
      pending_elements.insert(pending_elements.size(), pinned ? pinned_val : predicted);
      requests_sent++;
      if (restart) restarts_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and let every owed response come back, then idle for settle cycles.
   task automatic drain_block(int settle);
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_csr(logic [hmcg_pkg::CSR_ADDR_W-1:0] addr,
                            logic [hmcg_pkg::RES_W-1:0] data);
      drain_block(CSR_SETTLE);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      apply_csr(addr, data);
      csr_writes++;
   endtask

   function automatic stim_row_type item_row(bit restart, bit pinned, hex_elem_type want);
      stim_row_type r;
      r.kind    = ROW_ITEM;
      r.addr    = '0;
      r.wdata   = '0;
      r.restart = restart;
      r.pinned  = pinned;
      r.want    = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [hmcg_pkg::CSR_ADDR_W-1:0] addr,
                                            logic [hmcg_pkg::RES_W-1:0] data);
      stim_row_type r;
      r.kind    = ROW_CSR;
      r.addr    = addr;
      r.wdata   = data;
      r.restart = 1'b0;
      r.pinned  = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   // Random resolution: mostly tiny grids so walks wrap often, plus the
   // zero, maximum, above-maximum and in-between register values.
   function automatic logic [hmcg_pkg::RES_W-1:0] pick_edge();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return hmcg_pkg::RES_W'(hmcg_pkg::MAX_RES);
         2:       return hmcg_pkg::RES_W'($urandom_range(hmcg_pkg::MAX_RES + 1, 511));
         3:       return hmcg_pkg::RES_W'($urandom_range(5, hmcg_pkg::MAX_RES - 1));
         default: return hmcg_pkg::RES_W'($urandom_range(1, 4));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response side: ready follows a randomly picked mode, from always ready
   // up to heavy stalling. Once, on request, it holds off for a long stretch
   // so the block backs up into the request side.
   // ---------------------------------------------------------------------
   initial begin : response_pacer
      int stall_menu [5];
      int mode_left;
      int stall_pct;
      int hold_left;
      stall_menu = '{0, 0, 20, 50, 85};
      mode_left = 0;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_trigger && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_pct = stall_menu[$urandom_range(0, 4)];
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Compare every response transaction with the oldest owed element.
   always @(posedge clock) begin : response_check
      hex_elem_type got;
      hex_elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata};
         if (pending_elements.size() == 0) begin
            report_mismatch("response with nothing owed, element_index", got.index, 0);
         end else begin
            want = pending_elements.pop_front();
            if (got.index !== want.index)
               report_mismatch("element_index", got.index, want.index);
            for (int k = 0; k < 8; k++) begin
               if (got.corner[k] !== want.corner[k])
                  report_mismatch($sformatf("corner_%c of element %0d", 8'h61 + k, want.index),
                                  got.corner[k], want.corner[k]);
            end
            if (got.final_elem !== want.final_elem)
               report_mismatch($sformatf("final_element of element %0d", want.index),
                               got.final_elem, want.final_elem);
            if (want.final_elem) wraps_seen++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired with %0d responses still owed", pending_elements.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      hex_elem_type unit_cell;
      hex_elem_type tall_first;
      hex_elem_type none;
      int           phase_items;
      int           target;
      bit           first_phase;

      // Single element of a 1x1x1 grid: lattice 2x2x2, y mirrored.
      unit_cell.index      = '0;
      unit_cell.corner     = {25'd4, 25'd5, 25'd7, 25'd6, 25'd0, 25'd1, 25'd3, 25'd2};
      unit_cell.final_elem = 1'b1;
      // First element of a 1x256x1 grid: top row is y=256, lattice width 2, plane 514.
      tall_first.index      = '0;
      tall_first.corner     = {25'd1024, 25'd1025, 25'd1027, 25'd1026,
                               25'd510, 25'd511, 25'd513, 25'd512};
      tall_first.final_elem = 1'b0;
      none = '0;

      // Out of reset: 1x1x1, every request gives the same lone element.
      add_row(item_row(1'b0, 1'b1, unit_cell));
      add_row(item_row(1'b1, 1'b1, unit_cell));
      add_row(item_row(1'b0, 1'b1, unit_cell));
      // Zero resolution acts as one.
      add_row(csr_row(hmcg_pkg::CSR_RES_X, 9'd0));
      add_row(item_row(1'b0, 1'b1, unit_cell));
      // Oversized resolution clamps to the maximum.
      add_row(csr_row(hmcg_pkg::CSR_RES_Y, 9'd511));
      add_row(item_row(1'b0, 1'b1, tall_first));
      add_row(item_row(1'b0, 1'b0, none));
      add_row(item_row(1'b1, 1'b1, tall_first));   // restart mid-walk
      add_row(item_row(1'b0, 1'b0, none));
      // Unknown register index: ignored, walk keeps going.
      add_row(csr_row(CSR_UNUSED, 9'd5));
      add_row(item_row(1'b0, 1'b0, none));
      // Largest grid.
      add_row(csr_row(hmcg_pkg::CSR_RES_X, 9'd256));
      add_row(csr_row(hmcg_pkg::CSR_RES_Y, 9'd256));
      add_row(csr_row(hmcg_pkg::CSR_RES_Z, 9'd256));
      add_row(item_row(1'b0, 1'b0, none));
      add_row(item_row(1'b0, 1'b0, none));
      add_row(item_row(1'b1, 1'b0, none));
      // 2x3x2 grid: twelve elements, then one more to see the wrap.
      add_row(csr_row(hmcg_pkg::CSR_RES_X, 9'd2));
      add_row(csr_row(hmcg_pkg::CSR_RES_Y, 9'd3));
      add_row(csr_row(hmcg_pkg::CSR_RES_Z, 9'd2));
      for (int i = 0; i < 13; i++)
         add_row(item_row(1'b0, 1'b0, none));

      grid_res[0] = hmcg_pkg::RES_W'(1);
      grid_res[1] = hmcg_pkg::RES_W'(1);
      grid_res[2] = hmcg_pkg::RES_W'(1);
      send_home();

      // Synchronous reset, held from time zero and never repeated.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].addr, directed_rows[i].wdata);
         else
            send_request(directed_rows[i].restart, directed_rows[i].pinned,
                         directed_rows[i].want);
      end

      // Random phases: new grid settings, then a run of mostly plain
      // continue requests with an occasional restart.
      target = requests_sent + ITEM_TARGET;
      first_phase = 1'b1;
      while (requests_sent < target) begin
         if ($urandom_range(0, 3) != 0) write_csr(hmcg_pkg::CSR_RES_X, pick_edge());
         if ($urandom_range(0, 3) != 0) write_csr(hmcg_pkg::CSR_RES_Y, pick_edge());
         if ($urandom_range(0, 3) != 0) write_csr(hmcg_pkg::CSR_RES_Z, pick_edge());
         if ($urandom_range(0, 5) == 0)
            write_csr(CSR_UNUSED, hmcg_pkg::RES_W'($urandom_range(0, 511)));
         if (first_phase) begin
            hold_trigger = 1'b1;   // receiver stalls while requests keep coming
            first_phase = 1'b0;
         end
         phase_items = $urandom_range(20, 120);
         for (int n = 0; n < phase_items; n++)
            send_request($urandom_range(0, 31) == 0, 1'b0, none);
      end

      drain_block(TAIL_CYCLES);

      $display("Run covered %0d requests (%0d restarts) across %0d register writes,",
               requests_sent, restarts_sent, csr_writes);
      $display("with %0d grid wraps seen and resolutions from zero to above the maximum.",
               wraps_seen);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
design/hmcg_pkg.sv
design/hmcg_ctrl.sv
design/hmcg_datapath.sv
design/hex_mesh_connectivity_generator_top.sv
bench/tb_hex_mesh_connectivity_generator_top.sv
